>>> hw/rtl/ttag_pkg.sv
// shared types, codes and constants of the take-along-axis gather unit
`default_nettype none
package ttag_pkg;

    // fixed field widths
    localparam int POS_W = 12;
    localparam int DIM_W = 13;
    localparam int VAL_W = 64;
    localparam int NUM_DIM = 4;
    localparam int CFG_W = 13;
    localparam int IDX_W = 3;

    // positions never reach this, so a larger total acts the same
    localparam logic [DIM_W-1:0] TOTAL_CAP = DIM_W'(2 ** POS_W);

    // parameter defaults
    localparam int MAX_RANK_DEF = 4;
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int ELEMENT_WIDTH_DEF = 64;

    // item operations
    typedef enum logic [1:0] {
        OP_WR_SRC = 2'd0,
        OP_WR_IDX = 2'd1,
        OP_GATHER = 2'd2
    } op_t;

    // result status
    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_AXIS = 2'd1,
        ST_POS = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_RANK = 3'd0,
        REG_AXIS = 3'd1,
        REG_DIM0 = 3'd2,
        REG_DIM1 = 3'd3,
        REG_DIM2 = 3'd4,
        REG_DIM3 = 3'd5,
        REG_MASK = 3'd6
    } reg_idx_t;

    // item fields carried down the pipeline
    typedef struct packed {
        logic [1:0] op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        status_t status;
    } side_t;

endpackage
`default_nettype wire

>>> hw/rtl/ttag_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ttag_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ttag_coord.sv
// pipelined split of a flat position into coordinates, half a division per stage
`default_nettype none
module ttag_coord #(
    parameter int MAX_RANK = ttag_pkg::MAX_RANK_DEF,
    parameter int AXW = 3
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire ttag_pkg::side_t                          in_side,
    input  wire logic [AXW-1:0]                           in_ax,
    input  wire logic [MAX_RANK-1:0][ttag_pkg::DIM_W-1:0] ed,
    output logic                                          out_valid,
    output ttag_pkg::side_t                               out_side,
    output logic      [AXW-1:0]                           out_ax,
    output logic      [MAX_RANK-1:0][ttag_pkg::DIM_W-1:0] out_coord,
    output logic      [ttag_pkg::DIM_W-1:0]               out_total
);

    localparam int NST = 2 * MAX_RANK;
    localparam int PW = ttag_pkg::POS_W;
    localparam int DW = ttag_pkg::DIM_W;
    localparam int HB = PW / 2;

    // stage inputs
    logic                          s_valid [0:NST-1];
    ttag_pkg::side_t               s_side  [0:NST-1];
    logic [AXW-1:0]                s_ax    [0:NST-1];
    logic [DW-1:0]                 s_p     [0:NST-1];
    logic [PW-1:0]                 s_dv    [0:NST-1];
    logic [DW-1:0]                 s_t     [0:NST-1];
    logic [MAX_RANK-1:0][DW-1:0]   s_crd   [0:NST-1];

    // stage registers
    logic                          valid_reg [0:NST-1];
    ttag_pkg::side_t               side_reg  [0:NST-1];
    logic [AXW-1:0]                ax_reg    [0:NST-1];
    logic [DW-1:0]                 p_reg     [0:NST-1];
    logic [PW-1:0]                 dv_reg    [0:NST-1];
    logic [DW-1:0]                 t_reg     [0:NST-1];
    logic [MAX_RANK-1:0][DW-1:0]   crd_reg   [0:NST-1];

    for (genvar j = 0; j < NST; j++)
    begin : g_stage
        localparam int K = MAX_RANK - 1 - j / 2;
        localparam bit LAST_HALF = (j % 2) == 1;

        logic [DW-1:0]               p_next;
        logic [PW-1:0]               dv_next;
        logic [DW-1:0]               t_next;
        logic [MAX_RANK-1:0][DW-1:0] crd_next;
        logic [DW-1:0]               p_w;
        logic [PW-1:0]               d_w;
        logic [DW:0]                 ps;
        logic [2*DW-1:0]             prod;

        // stage input select
        if (j == 0)
        begin : g_first
            assign s_valid[j] = in_valid;
            assign s_side[j]  = in_side;
            assign s_ax[j]    = in_ax;
            assign s_p[j]     = '0;
            assign s_dv[j]    = in_side.pos;
            assign s_t[j]     = DW'(1);
            assign s_crd[j]   = '0;
        end
        else
        begin : g_next
            assign s_valid[j] = valid_reg[j-1];
            assign s_side[j]  = side_reg[j-1];
            assign s_ax[j]    = ax_reg[j-1];
            assign s_p[j]     = p_reg[j-1];
            assign s_dv[j]    = dv_reg[j-1];
            assign s_t[j]     = t_reg[j-1];
            assign s_crd[j]   = crd_reg[j-1];
        end

        // restoring division steps, quotient bits shift into the dividend
        always_comb
        begin
            p_w = s_p[j];
            d_w = s_dv[j];
            ps = '0;
            for (int i = 0; i < HB; i++)
            begin
                ps = {p_w, d_w[PW-1]};
                d_w = {d_w[PW-2:0], 1'b0};
                if (ps >= {1'b0, ed[K]})
                begin
                    ps = ps - {1'b0, ed[K]};
                    d_w[0] = 1'b1;
                end
                p_w = ps[DW-1:0];
            end
            dv_next = d_w;
            crd_next = s_crd[j];
            if (LAST_HALF)
            begin
                crd_next[K] = p_w;
                p_next = '0;
            end
            else
            begin
                p_next = p_w;
            end
        end

        // saturating running product of the lengths
        always_comb
        begin
            prod = s_t[j] * ed[K];
            if (LAST_HALF)
            begin
                t_next = s_t[j];
            end
            else if (prod > (2*DW)'(ttag_pkg::TOTAL_CAP))
            begin
                t_next = ttag_pkg::TOTAL_CAP;
            end
            else
            begin
                t_next = prod[DW-1:0];
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= s_valid[j];
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= s_side[j];
                ax_reg[j]   <= s_ax[j];
                p_reg[j]    <= p_next;
                dv_reg[j]   <= dv_next;
                t_reg[j]    <= t_next;
                crd_reg[j]  <= crd_next;
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign out_ax    = ax_reg[NST-1];
    assign out_coord = crd_reg[NST-1];
    assign out_total = t_reg[NST-1];

endmodule
`default_nettype wire

>>> hw/rtl/ttag_addr.sv
// pipelined address build: index address, source base and axis stride, one dimension a stage
`default_nettype none
module ttag_addr #(
    parameter int MAX_RANK = ttag_pkg::MAX_RANK_DEF,
    parameter int AXW = 3,
    parameter int AW = 12
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire ttag_pkg::side_t                          in_side,
    input  wire logic [AXW-1:0]                           in_ax,
    input  wire logic [MAX_RANK-1:0][ttag_pkg::DIM_W-1:0] in_coord,
    input  wire logic [MAX_RANK-1:0][ttag_pkg::DIM_W-1:0] ed,
    input  wire logic [MAX_RANK-1:0]                      bc,
    output logic                                          out_valid,
    output ttag_pkg::side_t                               out_side,
    output logic      [AXW-1:0]                           out_ax,
    output logic      [AW-1:0]                            out_iaddr,
    output logic      [AW-1:0]                            out_base,
    output logic      [AW-1:0]                            out_stride
);

    localparam int DW = ttag_pkg::DIM_W;
    localparam int MW = AW + DW + 1;

    // stage inputs
    logic                        s_valid [0:MAX_RANK-1];
    ttag_pkg::side_t             s_side  [0:MAX_RANK-1];
    logic [AXW-1:0]              s_ax    [0:MAX_RANK-1];
    logic [MAX_RANK-1:0][DW-1:0] s_crd   [0:MAX_RANK-1];
    logic [AW-1:0]               s_i     [0:MAX_RANK-1];
    logic [AW-1:0]               s_b     [0:MAX_RANK-1];
    logic [AW-1:0]               s_s     [0:MAX_RANK-1];

    // stage registers
    logic                        valid_reg [0:MAX_RANK-1];
    ttag_pkg::side_t             side_reg  [0:MAX_RANK-1];
    logic [AXW-1:0]              ax_reg    [0:MAX_RANK-1];
    logic [MAX_RANK-1:0][DW-1:0] crd_reg   [0:MAX_RANK-1];
    logic [AW-1:0]               i_reg     [0:MAX_RANK-1];
    logic [AW-1:0]               b_reg     [0:MAX_RANK-1];
    logic [AW-1:0]               s_reg     [0:MAX_RANK-1];

    for (genvar j = 0; j < MAX_RANK; j++)
    begin : g_stage
        logic [MW-1:0] mi;
        logic [MW-1:0] mb;
        logic [MW-1:0] ms;
        logic [AW-1:0] i_next;
        logic [AW-1:0] b_next;
        logic [AW-1:0] s_next;
        logic          is_ax;
        logic          past_ax;

        // stage input select
        if (j == 0)
        begin : g_first
            assign s_valid[j] = in_valid;
            assign s_side[j]  = in_side;
            assign s_ax[j]    = in_ax;
            assign s_crd[j]   = in_coord;
            assign s_i[j]     = '0;
            assign s_b[j]     = '0;
            assign s_s[j]     = AW'(1);
        end
        else
        begin : g_next
            assign s_valid[j] = valid_reg[j-1];
            assign s_side[j]  = side_reg[j-1];
            assign s_ax[j]    = ax_reg[j-1];
            assign s_crd[j]   = crd_reg[j-1];
            assign s_i[j]     = i_reg[j-1];
            assign s_b[j]     = b_reg[j-1];
            assign s_s[j]     = s_reg[j-1];
        end

        // horner steps, addresses wrap at the store depth
        always_comb
        begin
            is_ax = s_ax[j] == AXW'(j);
            past_ax = AXW'(j) > s_ax[j];
            mi = MW'(s_i[j]) * MW'(ed[j]) + MW'(s_crd[j][j]);
            mb = MW'(s_b[j]) * MW'(ed[j]) + (is_ax ? '0 : MW'(s_crd[j][j]));
            ms = MW'(s_s[j]) * MW'(ed[j]);
            i_next = bc[j] ? s_i[j] : mi[AW-1:0];
            b_next = mb[AW-1:0];
            s_next = past_ax ? ms[AW-1:0] : s_s[j];
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= s_valid[j];
            end
        end

        // payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= s_side[j];
                ax_reg[j]   <= s_ax[j];
                crd_reg[j]  <= s_crd[j];
                i_reg[j]    <= i_next;
                b_reg[j]    <= b_next;
                s_reg[j]    <= s_next;
            end
        end
    end

    assign out_valid  = valid_reg[MAX_RANK-1];
    assign out_side   = side_reg[MAX_RANK-1];
    assign out_ax     = ax_reg[MAX_RANK-1];
    assign out_iaddr  = i_reg[MAX_RANK-1];
    assign out_base   = b_reg[MAX_RANK-1];
    assign out_stride = s_reg[MAX_RANK-1];

endmodule
`default_nettype wire

>>> hw/rtl/tensor_take_along_axis_gather_unit.sv
// top level of the take-along-axis gather unit
`default_nettype none
// Gathers one element per item along a configured axis from a row-major source
// tensor of up to MAX_RANK dimensions, using a stored index tensor. Write items
// (op 0 source, op 1 index) load either memory by flat address; a gather item
// (op 2) gives a flat output position and returns the element and a status.
// Every item gives exactly one result. The unit takes one item per clock while
// the result side does not stall; its pipeline is one input stage, two stages
// per dimension for the position split (a restoring divider of six quotient
// bits a stage), one stage per dimension for the address build, then index
// read, bounds check, stride multiply and source read. Writes land in
// the memories at the same pipeline points as the reads, so items keep stream
// order. Both memories start undefined; STORE_DEPTH is taken as a power of two
// so addresses wrap by truncation. The configuration may be written only while
// no item is in flight. A stall on the result side holds the whole pipeline.
module tensor_take_along_axis_gather_unit #(
    parameter int MAX_RANK = ttag_pkg::MAX_RANK_DEF,
    parameter int STORE_DEPTH = ttag_pkg::STORE_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = ttag_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [ttag_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [ttag_pkg::CFG_W-1:0]    cfg_data,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // op [1:0], position [13:2], value [77:14], zero fill [79:78]
    input  wire logic [79:0]                   s_axis_tdata,
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // element [63:0], status [65:64], zero fill [71:66]
    output logic      [71:0]                   m_axis_tdata
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int AXW = $clog2(MAX_RANK + 1);
    localparam int DW = ttag_pkg::DIM_W;
    localparam int PW = ttag_pkg::POS_W;
    localparam int VW = ttag_pkg::VAL_W;
    localparam int RW = 5;

    // configuration registers
    logic [2:0]          rank_reg;
    logic [2:0]          axis_reg;
    logic [DW-1:0]       dim_reg [0:ttag_pkg::NUM_DIM-1];
    logic [3:0]          mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= 3'd1;
            axis_reg <= 3'd0;
            for (int d = 0; d < ttag_pkg::NUM_DIM; d++)
            begin
                dim_reg[d] <= DW'(1);
            end
            mask_reg <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ttag_pkg::REG_RANK: rank_reg <= cfg_data[2:0];
                ttag_pkg::REG_AXIS: axis_reg <= cfg_data[2:0];
                ttag_pkg::REG_DIM0: dim_reg[0] <= cfg_data[DW-1:0];
                ttag_pkg::REG_DIM1: dim_reg[1] <= cfg_data[DW-1:0];
                ttag_pkg::REG_DIM2: dim_reg[2] <= cfg_data[DW-1:0];
                ttag_pkg::REG_DIM3: dim_reg[3] <= cfg_data[DW-1:0];
                ttag_pkg::REG_MASK: mask_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective rank, clamped to 1..MAX_RANK
    logic [RW-1:0] r_eff;
    logic signed [RW-1:0] r_s;
    logic signed [RW-1:0] ax_s;
    logic signed [RW-1:0] ax_n;
    logic                 axis_bad;

    always_comb
    begin
        if (rank_reg == 3'd0)
        begin
            r_eff = RW'(1);
        end
        else if (RW'(rank_reg) > RW'(MAX_RANK))
        begin
            r_eff = RW'(MAX_RANK);
        end
        else
        begin
            r_eff = RW'(rank_reg);
        end
        r_s = signed'(r_eff);
        ax_s = RW'(signed'(axis_reg));
        axis_bad = (ax_s < -r_s) || (ax_s >= r_s);
        ax_n = (ax_s < 0) ? ax_s + r_s : ax_s;
    end

    // effective lengths and broadcast flags per dimension
    logic [MAX_RANK-1:0][DW-1:0] ed;
    logic [MAX_RANK-1:0]         bc;

    for (genvar d = 0; d < MAX_RANK; d++)
    begin : g_dim
        if (d < ttag_pkg::NUM_DIM)
        begin : g_reg
            assign ed[d] = (RW'(d) < r_eff) ? dim_reg[d] : DW'(1);
            assign bc[d] = mask_reg[d];
        end
        else
        begin : g_unit
            assign ed[d] = DW'(1);
            assign bc[d] = 1'b0;
        end
    end

    // global advance: the result register is free or being taken
    logic en;
    logic o_valid_reg;

    assign en = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // input stage
    logic            in_valid_reg;
    ttag_pkg::side_t in_side_reg;
    logic [AXW-1:0]  in_ax_reg;
    ttag_pkg::side_t in_side_next;

    always_comb
    begin
        in_side_next.op = s_axis_tdata[1:0];
        in_side_next.pos = s_axis_tdata[PW+1:2];
        in_side_next.value = s_axis_tdata[VW+PW+1:PW+2];
        if (s_axis_tdata[1:0] == ttag_pkg::OP_GATHER && axis_bad)
        begin
            in_side_next.status = ttag_pkg::ST_AXIS;
        end
        else
        begin
            in_side_next.status = ttag_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_side_reg <= in_side_next;
            in_ax_reg <= AXW'(unsigned'(ax_n));
        end
    end

    // position split
    logic                        c_valid;
    ttag_pkg::side_t             c_side;
    logic [AXW-1:0]              c_ax;
    logic [MAX_RANK-1:0][DW-1:0] c_coord;
    logic [DW-1:0]               c_total;
    ttag_pkg::side_t             c_side_chk;

    ttag_coord #(
        .MAX_RANK (MAX_RANK),
        .AXW      (AXW)
    ) u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_side   (in_side_reg),
        .in_ax     (in_ax_reg),
        .ed        (ed),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_ax    (c_ax),
        .out_coord (c_coord),
        .out_total (c_total)
    );

    // position against total
    always_comb
    begin
        c_side_chk = c_side;
        if (c_side.op == ttag_pkg::OP_GATHER && c_side.status == ttag_pkg::ST_OK
            && DW'(c_side.pos) >= c_total)
        begin
            c_side_chk.status = ttag_pkg::ST_POS;
        end
    end

    // address build
    logic            a_valid;
    ttag_pkg::side_t a_side;
    logic [AXW-1:0]  a_ax;
    logic [AW-1:0]   a_iaddr;
    logic [AW-1:0]   a_base;
    logic [AW-1:0]   a_stride;

    ttag_addr #(
        .MAX_RANK (MAX_RANK),
        .AXW      (AXW),
        .AW       (AW)
    ) u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (c_valid),
        .in_side    (c_side_chk),
        .in_ax      (c_ax),
        .in_coord   (c_coord),
        .ed         (ed),
        .bc         (bc),
        .out_valid  (a_valid),
        .out_side   (a_side),
        .out_ax     (a_ax),
        .out_iaddr  (a_iaddr),
        .out_base   (a_base),
        .out_stride (a_stride)
    );

    // index memory: writes and reads at the same stage
    logic [VW-1:0] idx_rd;

    ttag_ram #(
        .WIDTH (VW),
        .DEPTH (STORE_DEPTH)
    ) u_idx_ram (
        .clk     (clk),
        .wr_en   (en && a_valid && a_side.op == ttag_pkg::OP_WR_IDX),
        .wr_addr (AW'(a_side.pos)),
        .wr_data (a_side.value),
        .rd_en   (en),
        .rd_addr (a_iaddr),
        .rd_data (idx_rd)
    );

    // stage alongside the index read
    logic            x_valid_reg;
    ttag_pkg::side_t x_side_reg;
    logic [AXW-1:0]  x_ax_reg;
    logic [AW-1:0]   x_base_reg;
    logic [AW-1:0]   x_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            x_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_side_reg   <= a_side;
            x_ax_reg     <= a_ax;
            x_base_reg   <= a_base;
            x_stride_reg <= a_stride;
        end
    end

    // index wrap and bounds check
    logic [DW-1:0]    axis_len;
    logic signed [VW:0] sel_adj;
    logic             sel_bad;
    ttag_pkg::side_t  k_side_next;

    always_comb
    begin
        axis_len = DW'(1);
        for (int d = 0; d < MAX_RANK; d++)
        begin
            if (x_ax_reg == AXW'(d))
            begin
                axis_len = ed[d];
            end
        end
        sel_adj = signed'({idx_rd[VW-1], idx_rd});
        if (idx_rd[VW-1])
        begin
            sel_adj = sel_adj + signed'((VW+1)'(axis_len));
        end
        sel_bad = sel_adj[VW] || (unsigned'(sel_adj) >= (VW+1)'(axis_len));
        k_side_next = x_side_reg;
        if (x_side_reg.op == ttag_pkg::OP_GATHER && x_side_reg.status == ttag_pkg::ST_OK
            && sel_bad)
        begin
            k_side_next.status = ttag_pkg::ST_INDEX;
        end
    end

    logic            k_valid_reg;
    ttag_pkg::side_t k_side_reg;
    logic [DW-1:0]   k_sel_reg;
    logic [AW-1:0]   k_base_reg;
    logic [AW-1:0]   k_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k_valid_reg <= x_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_side_reg   <= k_side_next;
            k_sel_reg    <= sel_adj[DW-1:0];
            k_base_reg   <= x_base_reg;
            k_stride_reg <= x_stride_reg;
        end
    end

    // stride multiply
    logic [AW+DW-1:0] m_prod_next;
    logic             m_valid_reg;
    ttag_pkg::side_t  m_side_reg;
    logic [AW-1:0]    m_prod_reg;
    logic [AW-1:0]    m_base_reg;

    assign m_prod_next = (AW+DW)'(k_sel_reg) * (AW+DW)'(k_stride_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= k_side_reg;
            m_prod_reg <= m_prod_next[AW-1:0];
            m_base_reg <= k_base_reg;
        end
    end

    // source memory: writes and reads at the same stage
    logic [ELEMENT_WIDTH-1:0] src_rd;

    ttag_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_src_ram (
        .clk     (clk),
        .wr_en   (en && m_valid_reg && m_side_reg.op == ttag_pkg::OP_WR_SRC),
        .wr_addr (AW'(m_side_reg.pos)),
        .wr_data (m_side_reg.value[ELEMENT_WIDTH-1:0]),
        .rd_en   (en),
        .rd_addr (m_base_reg + m_prod_reg),
        .rd_data (src_rd)
    );

    // result register alongside the source read
    logic [1:0]        o_op_reg;
    ttag_pkg::status_t o_status_reg;
    logic [VW-1:0]     element;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_op_reg     <= m_side_reg.op;
            o_status_reg <= m_side_reg.status;
        end
    end

    // element is zero for writes and errors
    always_comb
    begin
        if (o_op_reg == ttag_pkg::OP_GATHER && o_status_reg == ttag_pkg::ST_OK)
        begin
            element = VW'(signed'(src_rd));
        end
        else
        begin
            element = '0;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {6'd0, o_status_reg, element};

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// testbench of the take-along-axis gather unit with its own gather predictor
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ttag_pkg::*;

    localparam int LATENCY = 17;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    typedef struct packed {
        logic [63:0] element;
        status_t status;
    } gather_result_t;

    // shadow state of the unit
    logic [63:0] src_mem [0:4095];
    logic [63:0] idx_mem [0:4095];
    bit src_written [0:4095];
    bit idx_written [0:4095];
    int unsigned rank_q;
    int axis_q;
    int unsigned dim_q [4];
    logic [3:0] mask_q;

    gather_result_t pending_results[$];
    int errors = 0;
    longint cycles = 0;
    int hold_cycles = 0;
    int rx_wait = 0;
    bit random_stall = 1'b1;

    tensor_take_along_axis_gather_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tensor_take_along_axis_gather_unit verification failed");
            $finish;
        end
    end

    // flat geometry in use
    function automatic int unsigned eff_rank();
        if (rank_q == 0)
            return 1;
        if (rank_q > 4)
            return 4;
        return rank_q;
    endfunction

    function automatic longint unsigned total_size();
        longint unsigned t;
        t = 1;
        for (int d = 0; d < eff_rank(); d++)
            t = t * dim_q[d];
        return t;
    endfunction

    // coordinate split of an output position
    function automatic void split_pos(input int unsigned pos, output int unsigned c [4]);
        int unsigned rem;
        rem = pos;
        for (int d = 3; d >= 0; d--)
        begin
            c[d] = 0;
            if (d < eff_rank())
            begin
                c[d] = rem % dim_q[d];
                rem = rem / dim_q[d];
            end
        end
    endfunction

    function automatic int unsigned index_addr(input int unsigned pos);
        int unsigned c [4];
        int unsigned a;
        split_pos(pos, c);
        a = 0;
        for (int d = 0; d < eff_rank(); d++)
            a = mask_q[d] ? a : a * dim_q[d] + c[d];
        return a % 4096;
    endfunction

    // expected result of one item, updating the shadow stores
    function automatic gather_result_t predict_gather(input op_t op,
            input logic [11:0] pos, input logic [63:0] value);
        gather_result_t res;
        int unsigned r, ax, c [4];
        longint sel, axis_len;
        longint unsigned saddr;
        res = '{element: '0, status: ST_OK};
        if (op == OP_WR_SRC)
        begin
            src_mem[pos] = value;
            src_written[pos] = 1'b1;
            return res;
        end
        if (op == OP_WR_IDX)
        begin
            idx_mem[pos] = value;
            idx_written[pos] = 1'b1;
            return res;
        end
        if (op != OP_GATHER)
            return res;
        r = eff_rank();
        if (axis_q < -int'(r) || axis_q >= int'(r))
        begin
            res.status = ST_AXIS;
            return res;
        end
        ax = (axis_q < 0) ? axis_q + r : axis_q;
        if (pos >= total_size())
        begin
            res.status = ST_POS;
            return res;
        end
        split_pos(pos, c);
        sel = idx_mem[index_addr(pos)];
        axis_len = dim_q[ax];
        if (sel < 0)
            sel = sel + axis_len;
        if (sel < 0 || sel >= axis_len)
        begin
            res.status = ST_INDEX;
            return res;
        end
        saddr = 0;
        for (int d = 0; d < r; d++)
            saddr = saddr * dim_q[d] + ((d == ax) ? sel : c[d]);
        res.element = src_mem[saddr % 4096];
        return res;
    endfunction

    // configuration write, only while idle
    task automatic write_reg(input reg_idx_t idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        case (idx)
            REG_RANK: rank_q = value & 7;
            REG_AXIS: axis_q = (value & 4) ? (value & 7) - 8 : (value & 7);
            REG_DIM0: dim_q[0] = value & 13'h1fff;
            REG_DIM1: dim_q[1] = value & 13'h1fff;
            REG_DIM2: dim_q[2] = value & 13'h1fff;
            REG_DIM3: dim_q[3] = value & 13'h1fff;
            REG_MASK: mask_q = value[3:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_shape(input int rk, input int ax, input int d0, input int d1,
            input int d2, input int d3, input int msk);
        drain();
        write_reg(REG_RANK, rk);
        write_reg(REG_AXIS, ax);
        write_reg(REG_DIM0, d0);
        write_reg(REG_DIM1, d1);
        write_reg(REG_DIM2, d2);
        write_reg(REG_DIM3, d3);
        write_reg(REG_MASK, msk);
        cfg_wr_en <= 1'b0;
    endtask

    // send one item with an optional random gap, record the expectation on accept
    task automatic send_item(input op_t op, input logic [11:0] pos,
            input logic [63:0] value, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, value, pos, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_gather(op, pos, value));
    endtask

    // gather of a position whose index entry (and source) is known
    function automatic bit gather_safe(input int unsigned pos);
        int unsigned r, ax, c [4];
        longint sel;
        longint unsigned saddr;
        r = eff_rank();
        if (axis_q < -int'(r) || axis_q >= int'(r) || pos >= total_size())
            return 1'b1;
        if (!idx_written[index_addr(pos)])
            return 1'b0;
        ax = (axis_q < 0) ? axis_q + r : axis_q;
        split_pos(pos, c);
        sel = idx_mem[index_addr(pos)];
        if (sel < 0)
            sel = sel + dim_q[ax];
        if (sel < 0 || sel >= dim_q[ax])
            return 1'b1;
        saddr = 0;
        for (int d = 0; d < r; d++)
            saddr = saddr * dim_q[d] + ((d == ax) ? sel : c[d]);
        return src_written[saddr % 4096];
    endfunction

    function automatic logic [63:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    // fill both stores across the shape with in-range and edge indexes
    task automatic load_tensors(input int unsigned n, input int unsigned axis_len);
        longint v;
        for (int unsigned a = 0; a < n; a++)
        begin
            send_item(OP_WR_SRC, 12'(a), rand_value(), 1'b1);
            case ($urandom_range(0, 9))
                0: v = axis_len;
                1: v = -longint'(axis_len) - 1;
                2: v = rand_value();
                default: v = longint'($urandom_range(0, 2 * axis_len - 1)) - axis_len;
            endcase
            send_item(OP_WR_IDX, 12'(a), v, 1'b1);
        end
    endtask

    // result checker with random waits per item and long holds
    always @(posedge clk)
    begin
        gather_result_t got, want;
        int w;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.element = m_axis_tdata[63:0];
            got.status = status_t'(m_axis_tdata[65:64]);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result element=%h status=%0d", got.element, got.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.element !== want.element)
                begin
                    $error("element expected %h actual %h", want.element, got.element);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!random_stall)
            m_axis_tready <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            w = $urandom_range(0, 15);
            rx_wait <= w;
            m_axis_tready <= (w == 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // edge values and every operation under a small 2-d shape, then axis and rank edge cases
    task automatic test_directed();
        set_shape(2, 1, 3, 4, 1, 1, 0);
        send_item(OP_WR_SRC, 12'd0, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_WR_SRC, 12'd3, 64'h0123_4567_89ab_cdef, 1'b0);
        send_item(OP_WR_SRC, 12'd8, 64'h8000_0000_0000_0001, 1'b0);
        send_item(OP_WR_SRC, 12'd11, 64'h7fff_ffff_ffff_ffff, 1'b0);
        send_item(OP_WR_SRC, 12'hfff, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_item(OP_WR_IDX, 12'd0, 64'd3, 1'b0);
        send_item(OP_WR_IDX, 12'd1, -64'sd3, 1'b0);
        send_item(OP_WR_IDX, 12'd11, -64'sd4, 1'b0);
        send_item(OP_WR_IDX, 12'd8, -64'sd1, 1'b0);
        send_item(OP_WR_IDX, 12'd4, 64'd4, 1'b0);
        send_item(OP_WR_IDX, 12'd5, -64'sd5, 1'b0);
        send_item(OP_WR_IDX, 12'hfff, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_GATHER, 12'd0, '0, 1'b0);
        send_item(OP_GATHER, 12'd11, '1, 1'b0);
        send_item(OP_GATHER, 12'd4, '0, 1'b0);
        send_item(OP_GATHER, 12'd5, '0, 1'b0);
        send_item(OP_GATHER, 12'd12, '0, 1'b0);
        send_item(OP_GATHER, 12'hfff, '0, 1'b0);
        send_item(op_t'(2'd3), 12'd0, '1, 1'b0);
        // axis out of range on both sides
        set_shape(2, 2, 3, 4, 1, 1, 0);
        send_item(OP_GATHER, 12'd0, '0, 1'b0);
        set_shape(2, -3, 3, 4, 1, 1, 0);
        send_item(OP_GATHER, 12'd0, '0, 1'b0);
        // rank zero and rank above four, zero length dimension
        set_shape(0, 0, 3, 1, 1, 1, 0);
        send_item(OP_GATHER, 12'd1, '0, 1'b0);
        set_shape(7, -1, 1, 1, 3, 4, 15);
        send_item(OP_GATHER, 12'd11, '0, 1'b0);
        set_shape(1, 0, 0, 1, 1, 1, 0);
        send_item(OP_GATHER, 12'd0, '0, 1'b0);
    endtask

    // given shape, random loads and mostly well-formed gathers
    task automatic test_random_shape(input int rk, input int ax, input int d0,
            input int d1, input int d2, input int d3, input int msk, input int gathers);
        int unsigned n, alen, ea, pos;
        int sent;
        set_shape(rk, ax, d0, d1, d2, d3, msk);
        n = 32'((total_size() > 64'd4096) ? 64'd4096 : total_size());
        ea = (axis_q < 0) ? axis_q + eff_rank() : axis_q;
        alen = (ea < 4 && ea < eff_rank()) ? dim_q[ea] : 1;
        load_tensors(n > 32 ? 32 : n, alen);
        sent = 0;
        while (sent < gathers)
        begin
            pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                  : $urandom_range(0, (n > 64 ? 64 : n) - 1);
            if (gather_safe(pos))
            begin
                send_item(OP_GATHER, 12'(pos), rand_value(), 1'b1);
                sent++;
            end
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        set_shape(1, 0, 16, 1, 1, 1, 0);
        load_tensors(16, 16);
        drain();
        hold_cycles = 200;
        for (int i = 0; i < 40; i++)
            send_item(OP_GATHER, 12'($urandom_range(0, 15)), '0, 1'b0);
        // sender pauses until everything has come back
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        random_stall = 1'b0;
        for (int i = 0; i < 30; i++)
            send_item(OP_GATHER, 12'($urandom_range(0, 15)), '0, 1'b0);
        random_stall = 1'b1;
    endtask

    initial
    begin
        rank_q = 1;
        axis_q = 0;
        dim_q = '{1, 1, 1, 1};
        mask_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_shape(3, -1, 2, 3, 4, 1, 2, 40);
        test_random_shape(4, 2, 2, 2, 3, 2, 9, 40);
        test_random_shape(4, -4, 4096, 1, 1, 1, 0, 40);
        test_random_shape(2, 0, 1, 4096, 1, 1, 1, 30);
        test_random_shape(1, -1, 40, 1, 1, 1, 0, 40);
        test_backpressure();
        drain();
        if (errors == 0)
            $display("tensor_take_along_axis_gather_unit verification clean");
        else
            $display("tensor_take_along_axis_gather_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
